[rtl/core/cau_pkg.sv]
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // operation selector carried on the input tuser
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // result status carried on the output tuser
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // per-item control that rides along the divider chain
    typedef struct packed {
        logic is_div;
        logic zero;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } t_ctl;

endpackage
`default_nettype wire

[rtl/core/cau_front.sv]
`default_nettype none
// Two stages: products and sums, then combine into values, divider numerators and divisor.
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire cau_pkg::t_op                  i_op,
    input  wire signed [DATA_WIDTH-1:0]        i_a_re,
    input  wire signed [DATA_WIDTH-1:0]        i_a_im,
    input  wire signed [DATA_WIDTH-1:0]        i_b_re,
    input  wire signed [DATA_WIDTH-1:0]        i_b_im,
    output logic                               o_valid,
    input  wire                                i_ready,
    output cau_pkg::t_ctl                      o_ctl,
    output logic signed [2*DATA_WIDTH:0]       o_val_re,
    output logic signed [2*DATA_WIDTH:0]       o_val_im,
    output logic [2*DATA_WIDTH:0]              o_rem_re,
    output logic [2*DATA_WIDTH:0]              o_rem_im,
    output logic [DATA_WIDTH-1:0]              o_low_re,
    output logic [DATA_WIDTH-1:0]              o_low_im,
    output logic [2*DATA_WIDTH:0]              o_den
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = 2*DATA_WIDTH + 1;
    localparam int EW = SW + FRAC_BITS + DATA_WIDTH;

    // stage A registers
    logic                  r_va;
    cau_pkg::t_op          r_op;
    logic signed [2*W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_r2, r_p_i2;
    logic signed [SW-1:0]  r_s_re, r_s_im;
    logic                  w_rdy_a, w_rdy_b;

    // stage B registers
    logic                  r_vb;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;

    // take an item into stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= i_valid;
        end
        if (w_rdy_a && i_valid) begin
            r_op   <= i_op;
            r_p_rr <= i_a_re * i_b_re;
            r_p_ii <= i_a_im * i_b_im;
            r_p_ri <= i_a_re * i_b_im;
            r_p_ir <= i_a_im * i_b_re;
            r_p_r2 <= i_b_re * i_b_re;
            r_p_i2 <= i_b_im * i_b_im;
            if (i_op == cau_pkg::OP_SUB) begin
                r_s_re <= SW'(i_a_re) - SW'(i_b_re);
                r_s_im <= SW'(i_a_im) - SW'(i_b_im);
            end else begin
                r_s_re <= SW'(i_a_re) + SW'(i_b_re);
                r_s_im <= SW'(i_a_im) + SW'(i_b_im);
            end
        end
    end

    // combine products
    logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir, e_r2, e_i2;
    logic signed [SW-1:0] n_mre, n_mim, n_nr, n_ni;
    logic [SW-1:0]        n_mag_re, n_mag_im, n_den;
    logic [EW-1:0]        n_dx_re, n_dx_im, n_dlim;

    assign e_rr = SW'(r_p_rr);
    assign e_ii = SW'(r_p_ii);
    assign e_ri = SW'(r_p_ri);
    assign e_ir = SW'(r_p_ir);
    assign e_r2 = SW'(r_p_r2);
    assign e_i2 = SW'(r_p_i2);

    always_comb begin
        n_mre    = (e_rr - e_ii) >>> FRAC_BITS;
        n_mim    = (e_ri + e_ir) >>> FRAC_BITS;
        n_nr     = e_rr + e_ii;
        n_ni     = e_ir - e_ri;
        n_mag_re = n_nr[SW-1] ? SW'(-n_nr) : n_nr;
        n_mag_im = n_ni[SW-1] ? SW'(-n_ni) : n_ni;
        n_den    = e_r2 + e_i2;
        n_dx_re  = EW'(n_mag_re) << FRAC_BITS;
        n_dx_im  = EW'(n_mag_im) << FRAC_BITS;
        n_dlim   = EW'(n_den) << W;
    end

    // advance into stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_rdy_b) begin
            r_vb <= r_va;
        end
        if (w_rdy_b && r_va) begin
            o_ctl.is_div <= (r_op == cau_pkg::OP_DIV);
            o_ctl.zero   <= (n_den == '0);
            o_ctl.neg_re <= n_nr[SW-1];
            o_ctl.neg_im <= n_ni[SW-1];
            o_ctl.ovf_re <= (n_dx_re >= n_dlim);
            o_ctl.ovf_im <= (n_dx_im >= n_dlim);
            o_val_re     <= (r_op == cau_pkg::OP_MUL) ? n_mre : r_s_re;
            o_val_im     <= (r_op == cau_pkg::OP_MUL) ? n_mim : r_s_im;
            o_rem_re     <= n_dx_re[W +: SW];
            o_rem_im     <= n_dx_im[W +: SW];
            o_low_re     <= n_dx_re[W-1:0];
            o_low_im     <= n_dx_im[W-1:0];
            o_den        <= n_den;
        end
    end
endmodule
`default_nettype wire

[rtl/core/cau_div_cell.sv]
`default_nettype none
// One restoring-division step for both parts; passes everything else along.
module cau_div_cell #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire cau_pkg::t_ctl                 i_ctl,
    input  wire signed [2*DATA_WIDTH:0]        i_val_re,
    input  wire signed [2*DATA_WIDTH:0]        i_val_im,
    input  wire [2*DATA_WIDTH:0]               i_rem_re,
    input  wire [2*DATA_WIDTH:0]               i_rem_im,
    input  wire [DATA_WIDTH-1:0]               i_low_re,
    input  wire [DATA_WIDTH-1:0]               i_low_im,
    input  wire [DATA_WIDTH-1:0]               i_q_re,
    input  wire [DATA_WIDTH-1:0]               i_q_im,
    input  wire [2*DATA_WIDTH:0]               i_den,
    output logic                               o_valid,
    input  wire                                i_ready,
    output cau_pkg::t_ctl                      o_ctl,
    output logic signed [2*DATA_WIDTH:0]       o_val_re,
    output logic signed [2*DATA_WIDTH:0]       o_val_im,
    output logic [2*DATA_WIDTH:0]              o_rem_re,
    output logic [2*DATA_WIDTH:0]              o_rem_im,
    output logic [DATA_WIDTH-1:0]              o_low_re,
    output logic [DATA_WIDTH-1:0]              o_low_im,
    output logic [DATA_WIDTH-1:0]              o_q_re,
    output logic [DATA_WIDTH-1:0]              o_q_im,
    output logic [2*DATA_WIDTH:0]              o_den
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = 2*DATA_WIDTH + 1;

    logic            r_valid;
    logic [SW:0]     w_sh_re, w_sh_im;
    logic            w_ge_re, w_ge_im;
    logic [SW:0]     w_df_re, w_df_im;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // bring down the next dividend bit and try the subtract
    always_comb begin
        w_sh_re = {i_rem_re, i_low_re[W-1]};
        w_sh_im = {i_rem_im, i_low_im[W-1]};
        w_ge_re = (w_sh_re >= {1'b0, i_den});
        w_ge_im = (w_sh_im >= {1'b0, i_den});
        w_df_re = w_sh_re - {1'b0, i_den};
        w_df_im = w_sh_im - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_ctl    <= i_ctl;
            o_val_re <= i_val_re;
            o_val_im <= i_val_im;
            o_rem_re <= w_ge_re ? w_df_re[SW-1:0] : w_sh_re[SW-1:0];
            o_rem_im <= w_ge_im ? w_df_im[SW-1:0] : w_sh_im[SW-1:0];
            o_low_re <= i_low_re << 1;
            o_low_im <= i_low_im << 1;
            o_q_re   <= {i_q_re[W-2:0], w_ge_re};
            o_q_im   <= {i_q_im[W-2:0], w_ge_im};
            o_den    <= i_den;
        end
    end
endmodule
`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
`default_nettype none
// Complex add / subtract / multiply / divide on signed fixed-point parts.
// Pipeline from input transaction to result, in order:
// two front stages, one divider cell per quotient bit, one saturation/output stage.
// Throughput: one transaction per cycle; every stage stalls only when full downstream.
// Reset (synchronous, active low) empties all stages; no other state is kept.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS,
    localparam int IN_W  = ((4*DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2*DATA_WIDTH + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire [IN_W-1:0]   i_s_tdata,   // a_re, a_im, b_re, b_im, zero pad
    input  wire [1:0]        i_s_tuser,   // op
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // res_re, res_im, zero pad
    output logic [1:0]       o_m_tuser    // status
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = 2*DATA_WIDTH + 1;
    localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    // divider chain links, index k feeds cell k
    logic                  c_valid  [0:W];
    logic                  c_ready  [0:W];
    cau_pkg::t_ctl         c_ctl    [0:W];
    logic signed [SW-1:0]  c_val_re [0:W];
    logic signed [SW-1:0]  c_val_im [0:W];
    logic [SW-1:0]         c_rem_re [0:W];
    logic [SW-1:0]         c_rem_im [0:W];
    logic [W-1:0]          c_low_re [0:W];
    logic [W-1:0]          c_low_im [0:W];
    logic [W-1:0]          c_q_re   [0:W];
    logic [W-1:0]          c_q_im   [0:W];
    logic [SW-1:0]         c_den    [0:W];

    logic r_out_valid;
    logic w_out_en;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_op     (cau_pkg::t_op'(i_s_tuser)),
        .i_a_re   (i_s_tdata[0*W +: W]),
        .i_a_im   (i_s_tdata[1*W +: W]),
        .i_b_re   (i_s_tdata[2*W +: W]),
        .i_b_im   (i_s_tdata[3*W +: W]),
        .o_valid  (c_valid[0]),
        .i_ready  (c_ready[0]),
        .o_ctl    (c_ctl[0]),
        .o_val_re (c_val_re[0]),
        .o_val_im (c_val_im[0]),
        .o_rem_re (c_rem_re[0]),
        .o_rem_im (c_rem_im[0]),
        .o_low_re (c_low_re[0]),
        .o_low_im (c_low_im[0]),
        .o_den    (c_den[0])
    );

    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        cau_div_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (c_valid[k]),
            .o_ready  (c_ready[k]),
            .i_ctl    (c_ctl[k]),
            .i_val_re (c_val_re[k]),
            .i_val_im (c_val_im[k]),
            .i_rem_re (c_rem_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_low_re (c_low_re[k]),
            .i_low_im (c_low_im[k]),
            .i_q_re   (c_q_re[k]),
            .i_q_im   (c_q_im[k]),
            .i_den    (c_den[k]),
            .o_valid  (c_valid[k+1]),
            .i_ready  (c_ready[k+1]),
            .o_ctl    (c_ctl[k+1]),
            .o_val_re (c_val_re[k+1]),
            .o_val_im (c_val_im[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_low_re (c_low_re[k+1]),
            .o_low_im (c_low_im[k+1]),
            .o_q_re   (c_q_re[k+1]),
            .o_q_im   (c_q_im[k+1]),
            .o_den    (c_den[k+1])
        );
    end

    assign w_out_en    = !r_out_valid || i_m_tready;
    assign c_ready[W]  = w_out_en;

    // signed quotient, capped at 2^W when the integer part already overflows
    function automatic logic signed [SW-1:0] quot_val(
        input logic         neg,
        input logic         ovf,
        input logic [W-1:0] q
    );
        logic signed [SW-1:0] mag;
        mag = ovf ? (SW'(1) <<< W) : SW'({1'b0, q});
        return neg ? -mag : mag;
    endfunction

    logic signed [SW-1:0] w_re, w_im;
    logic                 w_sat_re, w_sat_im;
    logic [W-1:0]         w_res_re, w_res_im;
    logic [1:0]           w_status;

    // pick the part values, saturate, and flag a zero divisor on divide
    always_comb begin
        if (c_ctl[W].is_div) begin
            w_re = quot_val(c_ctl[W].neg_re, c_ctl[W].ovf_re, c_q_re[W]);
            w_im = quot_val(c_ctl[W].neg_im, c_ctl[W].ovf_im, c_q_im[W]);
        end else begin
            w_re = c_val_re[W];
            w_im = c_val_im[W];
        end
        w_sat_re = (w_re > MAXV) || (w_re < MINV);
        w_sat_im = (w_im > MAXV) || (w_im < MINV);
        w_res_re = w_sat_re ? (w_re[SW-1] ? MINV[W-1:0] : MAXV[W-1:0]) : w_re[W-1:0];
        w_res_im = w_sat_im ? (w_im[SW-1] ? MINV[W-1:0] : MAXV[W-1:0]) : w_im[W-1:0];
        w_status = (w_sat_re || w_sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (c_ctl[W].is_div && c_ctl[W].zero) begin
            w_res_re = '0;
            w_res_im = '0;
            w_status = cau_pkg::ST_DZ;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= c_valid[W];
        end
        if (w_out_en && c_valid[W]) begin
            o_m_tdata <= OUT_W'({w_res_im, w_res_re});
            o_m_tuser <= w_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
endmodule
`default_nettype wire

[tb/tb_complex_arithmetic_unit.sv]
`default_nettype none
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int W      = cau_pkg::DATA_WIDTH;
    localparam int FB     = cau_pkg::FRAC_BITS;
    localparam int LAT    = W + 3;
    localparam int N_RAND = 1650;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic [1:0]   status;
    } t_cplx_res;

    // exact complex arithmetic on the four operand parts, with saturation and zero-divisor status
    function automatic t_cplx_res calc_result(t_op op, logic signed [W-1:0] ar,
                                              logic signed [W-1:0] ai,
                                              logic signed [W-1:0] br,
                                              logic signed [W-1:0] bi);
        longint vre, vim, nre, nim, den, lim_hi, lim_lo;
        t_cplx_res r;
        lim_hi = (64'sd1 <<< (W - 1)) - 1;
        lim_lo = -(64'sd1 <<< (W - 1));
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                vre = longint'(ar) + longint'(br);
                vim = longint'(ai) + longint'(bi);
            end
            OP_SUB: begin
                vre = longint'(ar) - longint'(br);
                vim = longint'(ai) - longint'(bi);
            end
            OP_MUL: begin
                vre = (longint'(ar) * br - longint'(ai) * bi) >>> FB;
                vim = (longint'(ar) * bi + longint'(ai) * br) >>> FB;
            end
            default: begin
                den = longint'(br) * br + longint'(bi) * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.status = ST_DZ;
                    return r;
                end
                nre = longint'(ar) * br + longint'(ai) * bi;
                nim = longint'(ai) * br - longint'(ar) * bi;
                // signed division truncates toward zero
                vre = (nre <<< FB) / den;
                vim = (nim <<< FB) / den;
            end
        endcase
        if (vre > lim_hi) begin vre = lim_hi; r.status = ST_SAT; end
        if (vre < lim_lo) begin vre = lim_lo; r.status = ST_SAT; end
        if (vim > lim_hi) begin vim = lim_hi; r.status = ST_SAT; end
        if (vim < lim_lo) begin vim = lim_lo; r.status = ST_SAT; end
        r.re = vre[W-1:0];
        r.im = vim[W-1:0];
        return r;
    endfunction

    int n_errors = 0;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    class cau_scoreboard;
        t_cplx_res pending_results[$];

        function void note_operands(t_op op, logic [W-1:0] ar, logic [W-1:0] ai,
                                    logic [W-1:0] br, logic [W-1:0] bi);
            pending_results.push_back(calc_result(op, ar, ai, br, bi));
        endfunction

        task check_result(logic [W-1:0] re, logic [W-1:0] im, logic [1:0] st);
            t_cplx_res e;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h %h %0d", re, im, st));
                return;
            end
            e = pending_results.pop_front();
            if (re !== e.re)
                report_mismatch($sformatf("res_re %h, expected %h", re, e.re));
            if (im !== e.im)
                report_mismatch($sformatf("res_im %h, expected %h", im, e.im));
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
        endtask
    endclass

    localparam int IN_W  = ((4*W + 7) / 8) * 8;
    localparam int OUT_W = ((2*W + 7) / 8) * 8;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tready = 1'b0;
    wire              s_tready;
    wire              m_tvalid;
    wire [OUT_W-1:0]  m_tdata;
    wire [1:0]        m_tuser;

    complex_arithmetic_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // a_re, a_im, b_re, b_im, zero pad
        .i_s_tuser  (s_tuser),   // op
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // res_re, res_im, zero pad
        .o_m_tuser  (m_tuser)    // status
    );

    always #5 i_clk = ~i_clk;

    cau_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    longint n_cycles = 0;

    // abort a hung run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_complex_arithmetic_unit: FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off window
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata[W-1:0], m_tdata[2*W-1:W], m_tuser);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one item and hold it until the transaction completes
    task automatic send_item(t_op op, logic [W-1:0] ar, logic [W-1:0] ai,
                             logic [W-1:0] br, logic [W-1:0] bi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({bi, br, ai, ar});
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_operands(op, ar, ai, br, bi);
    endtask

    function automatic logic [W-1:0] pick_part();
        case ($urandom_range(9))
            0: return {1'b0, {(W-1){1'b1}}};
            1: return {1'b1, {(W-1){1'b0}}};
            2: return '0;
            3: return W'($urandom_range(512)) - W'(256);
            4: return W'($urandom_range(64));
            default: return W'($urandom());
        endcase
    endfunction

    logic [W-1:0] pmax, pmin;
    t_op          op_cur;

    initial begin
        pmax = {1'b0, {(W-1){1'b1}}};
        pmin = {1'b1, {(W-1){1'b0}}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every op, saturation and zero divisor
        for (int k = 0; k < 4; k++) begin
            op_cur = t_op'(k);
            send_item(op_cur, pmax, pmax, pmax, pmax);
            send_item(op_cur, pmin, pmin, pmin, pmin);
            send_item(op_cur, pmax, pmin, pmin, pmax);
            send_item(op_cur, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        end
        send_item(OP_DIV, 16'h1234, 16'h5678, '0, '0);
        send_item(OP_DIV, pmin, pmax, 16'h0001, '0);
        send_item(OP_DIV, 16'hffff, 16'h0001, 16'h0300, 16'hfd00);
        send_item(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
        send_item(OP_DIV, '0, '0, '0, '0);

        // random phases with differing idle patterns
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RAND / 5; n++) begin
                op_cur = t_op'($urandom_range(3));
                send_item(op_cur, pick_part(), pick_part(), pick_part(), pick_part());
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_complex_arithmetic_unit: PASS");
        else
            $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
